### design/rlebsb_pkg.sv
// ----------------------------------------------------------------------------
// rlebsb_pkg: shared types and constants for the run-length span blitter
// Field widths, register indexes, the queued request layout, span records and
// the effective width and height helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rlebsb_pkg;

  // Field widths
  localparam int OFFSET_BITS = 22;
  localparam int ORG_W       = 10;
  localparam int COL_W       = 10;
  localparam int DIM_W       = 11;
  localparam int PITCH_W     = 12;
  localparam int COLOR_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int SHORT_W     = 7;
  localparam int RUN_W       = 15;
  localparam int DVD_W       = 16;
  localparam int PROD_W      = DVD_W + PITCH_W;

  // Bitmap limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Width divider: quotient bits retired per cycle
  localparam int DIV_DIGIT = 4;
  localparam int DIV_ITERS = DVD_W / DIV_DIGIT;
  localparam int DIV_CNT_W = 2;

  // Span slots per request
  localparam int SPAN_SLOTS = 3;
  localparam int SLOT_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_LINE_PITCH    = 3'd2,
    CFG_BITMAP_WIDTH  = 3'd3,
    CFG_BITMAP_HEIGHT = 3'd4,
    CFG_DRAW_COLOR    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [PITCH_W-1:0] line_pitch;
    logic [DIM_W-1:0]   bitmap_width;
    logic [DIM_W-1:0]   bitmap_height;
    logic [COLOR_W-1:0] draw_color;
  } cfg_t;

  // One decoded request: optional run, optional tail fill
  typedef struct packed {
    logic             start;
    logic             run_valid;
    logic             run_fg;
    logic [RUN_W-1:0] run_len;
    logic             fin;
    logic             tail_fg;
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [DIM_W-1:0]       length;
    logic [DIM_W-1:0]       rows;
  } span_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_INIT,
    BK_REDUCE,
    BK_RDIV,
    BK_RUN,
    BK_DIV,
    BK_MUL,
    BK_PLAN,
    BK_TAIL,
    BK_EMIT
  } back_state_t;

  // Width register as used: zero reads as one, large values saturate
  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = DIM_W'(1);
    end else if (w > DIM_W'(MAX_WIDTH)) begin
      r = DIM_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] r;
    r = h;
    if (h > DIM_W'(MAX_HEIGHT)) begin
      r = DIM_W'(MAX_HEIGHT);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/rle_bitmap_span_blitter.sv
// ----------------------------------------------------------------------------
// rle_bitmap_span_blitter: run-length bitmap to framebuffer span converter
// Usage:
//   Input channel (in_valid/in_stall) takes one code byte per request; set
//   in_final_byte on the last byte of a bitmap. The next byte starts a new
//   image. Result channel (out_valid/out_stall) gives fill spans: word
//   offset, length per row, row count and color; out_last_span marks the
//   last span caused by one byte. Bytes that complete no foreground run
//   give no span, unless a final byte leaves a foreground tail to fill.
//   Write cfg_* only while the block is idle.
//   The decoder takes a byte every cycle while the queue is not full, into a
//   four-deep request queue. The span engine handles one request at a time:
//   a byte that ends a run passes through the radix-16 width divider, each
//   span is sent in turn, image start adds an init step and a width that
//   shrank under the current column adds a reducing divide. The engine's
//   divider and sequencing set the sustained rate.
//   Reset clears the decoder, the queue and the engine and restores the
//   register defaults. A stalled receiver holds the output register; the
//   engine waits and the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_bitmap_span_blitter (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_we,
  input  wire [rlebsb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [rlebsb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // code bytes
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire [rlebsb_pkg::BYTE_W-1:0]          in_code_byte,
  input  wire                                   in_final_byte,
  // spans
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [rlebsb_pkg::OFFSET_BITS-1:0]    out_span_offset,
  output logic [rlebsb_pkg::DIM_W-1:0]          out_span_length,
  output logic [rlebsb_pkg::DIM_W-1:0]          out_span_rows,
  output logic [rlebsb_pkg::COLOR_W-1:0]        out_pixel_value,
  output logic                                  out_last_span
);

  rlebsb_pkg::cfg_t  cfg_r;
  logic              q_full, q_push, q_pop, q_valid;
  rlebsb_pkg::cmd_t  push_cmd, head_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.line_pitch    <= rlebsb_pkg::PITCH_W'(1);
      cfg_r.bitmap_width  <= rlebsb_pkg::DIM_W'(1);
      cfg_r.bitmap_height <= '0;
      cfg_r.draw_color    <= '0;
    end else if (cfg_we) begin
      unique case (rlebsb_pkg::cfg_idx_t'(cfg_index))
        rlebsb_pkg::CFG_ORIGIN_X:
          cfg_r.origin_x <= cfg_wdata[rlebsb_pkg::ORG_W-1:0];
        rlebsb_pkg::CFG_ORIGIN_Y:
          cfg_r.origin_y <= cfg_wdata[rlebsb_pkg::ORG_W-1:0];
        rlebsb_pkg::CFG_LINE_PITCH:
          cfg_r.line_pitch <= cfg_wdata[rlebsb_pkg::PITCH_W-1:0];
        rlebsb_pkg::CFG_BITMAP_WIDTH:
          cfg_r.bitmap_width <= cfg_wdata[rlebsb_pkg::DIM_W-1:0];
        rlebsb_pkg::CFG_BITMAP_HEIGHT:
          cfg_r.bitmap_height <= cfg_wdata[rlebsb_pkg::DIM_W-1:0];
        rlebsb_pkg::CFG_DRAW_COLOR:
          cfg_r.draw_color <= cfg_wdata[rlebsb_pkg::COLOR_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  rlebsb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_code_byte  (in_code_byte),
    .in_final_byte (in_final_byte),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  rlebsb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  rlebsb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_span_offset (out_span_offset),
    .out_span_length (out_span_length),
    .out_span_rows   (out_span_rows),
    .out_pixel_value (out_pixel_value),
    .out_last_span   (out_last_span)
  );

endmodule

`default_nettype wire

### design/rlebsb_front.sv
// ----------------------------------------------------------------------------
// rlebsb_front: code byte decoder
// Pairs long-run halves, tracks polarity and image start, and pushes one
// request per accepted byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rlebsb_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire [rlebsb_pkg::BYTE_W-1:0]     in_code_byte,
  input  wire                              in_final_byte,
  output logic                             in_stall,
  input  wire                              q_full,
  output logic                             push,
  output rlebsb_pkg::cmd_t                 push_cmd
);

  logic                               in_image_r, in_image_nxt;
  logic                               hp_r, hp_nxt;
  logic                               fg_r, fg_nxt;
  logic [rlebsb_pkg::SHORT_W-1:0]     high_r, high_nxt;
  logic                               hp_cur, fg_cur;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Decode one byte against the pending half and polarity
  always_comb begin
    hp_cur   = in_image_r && hp_r;
    fg_cur   = in_image_r && fg_r;
    hp_nxt   = hp_cur;
    fg_nxt   = fg_cur;
    high_nxt = high_r;

    push_cmd           = '0;
    push_cmd.start     = !in_image_r;
    push_cmd.run_fg    = fg_cur;
    push_cmd.fin       = in_final_byte;

    priority if (hp_cur) begin
      push_cmd.run_valid = 1'b1;
      push_cmd.run_len   = {high_r, in_code_byte};
      fg_nxt             = !fg_cur;
      hp_nxt             = 1'b0;
    end else if (!in_code_byte[rlebsb_pkg::BYTE_W-1]) begin
      // high half of a long run; a final one is dropped
      if (!in_final_byte) begin
        hp_nxt   = 1'b1;
        high_nxt = in_code_byte[rlebsb_pkg::SHORT_W-1:0];
      end
    end else begin
      push_cmd.run_valid = 1'b1;
      push_cmd.run_len   = rlebsb_pkg::RUN_W'(in_code_byte[rlebsb_pkg::SHORT_W-1:0]);
      fg_nxt             = !fg_cur;
    end

    push_cmd.tail_fg = fg_nxt;
    in_image_nxt     = !in_final_byte;
    if (in_final_byte) begin
      hp_nxt = 1'b0;
    end
  end

  // Advance decode state on each pushed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_image_r <= 1'b0;
      hp_r       <= 1'b0;
      fg_r       <= 1'b0;
    end else if (push) begin
      in_image_r <= in_image_nxt;
      hp_r       <= hp_nxt;
      fg_r       <= fg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      high_r <= high_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rlebsb_queue.sv
// ----------------------------------------------------------------------------
// rlebsb_queue: request queue between decoder and span engine
// Four-entry first-in first-out buffer of decoded requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rlebsb_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  rlebsb_pkg::cmd_t    push_cmd,
  output logic                full,
  input  wire                 pop,
  output logic                valid,
  output rlebsb_pkg::cmd_t    head
);

  rlebsb_pkg::cmd_t                 mem_r [rlebsb_pkg::Q_DEPTH];
  logic [rlebsb_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [rlebsb_pkg::Q_CNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == rlebsb_pkg::Q_CNT_W'(rlebsb_pkg::Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/rlebsb_div.sv
// ----------------------------------------------------------------------------
// rlebsb_div: iterative divider by the bitmap width
// Radix-16 restoring divider: four quotient bits per cycle while busy, over a
// 16-bit dividend. done pulses one cycle with quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rlebsb_div (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire [rlebsb_pkg::DVD_W-1:0]      dividend,
  input  wire [rlebsb_pkg::DIM_W-1:0]      divisor,
  output logic                             done,
  output logic [rlebsb_pkg::DVD_W-1:0]     quot,
  output logic [rlebsb_pkg::DIM_W-1:0]     rem
);

  logic [rlebsb_pkg::DVD_W-1:0]     work_r, work_nxt;
  logic [rlebsb_pkg::DIM_W-1:0]     rem_r, rem_nxt;
  logic [rlebsb_pkg::DIM_W-1:0]     dsr_r;
  logic [rlebsb_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                             busy_r, done_r;

  assign done = done_r;
  assign quot = work_r;
  assign rem  = rem_r;

  // Retire one radix-16 digit
  always_comb begin : div_digit
    logic [rlebsb_pkg::DIM_W:0]       trial;
    logic [rlebsb_pkg::DIM_W-1:0]     r;
    logic [rlebsb_pkg::DIV_DIGIT-1:0] q;
    r = rem_r;
    q = '0;
    for (int i = 0; i < rlebsb_pkg::DIV_DIGIT; i++) begin
      trial = {r, work_r[rlebsb_pkg::DVD_W-1-i]};
      if (trial >= {1'b0, dsr_r}) begin
        trial                          = trial - {1'b0, dsr_r};
        q[rlebsb_pkg::DIV_DIGIT-1-i]   = 1'b1;
      end
      r = trial[rlebsb_pkg::DIM_W-1:0];
    end
    rem_nxt  = r;
    work_nxt = {work_r[rlebsb_pkg::DVD_W-rlebsb_pkg::DIV_DIGIT-1:0], q};
  end

  // Load operands or step the shared remainder and quotient registers
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rlebsb_pkg::DIV_CNT_W'(rlebsb_pkg::DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/rlebsb_back.sv
// ----------------------------------------------------------------------------
// rlebsb_back: span engine
// Pops decoded requests, walks the run over the bitmap with the width
// divider, plans up to three fill spans and sends them through a registered
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlebsb_back (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  rlebsb_pkg::cfg_t                      cfg,
  input  wire                                   q_valid,
  input  rlebsb_pkg::cmd_t                      q_cmd,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [rlebsb_pkg::OFFSET_BITS-1:0]    out_span_offset,
  output logic [rlebsb_pkg::DIM_W-1:0]          out_span_length,
  output logic [rlebsb_pkg::DIM_W-1:0]          out_span_rows,
  output logic [rlebsb_pkg::COLOR_W-1:0]        out_pixel_value,
  output logic                                  out_last_span
);

  localparam int OB = rlebsb_pkg::OFFSET_BITS;
  localparam int DW = rlebsb_pkg::DIM_W;
  localparam int VW = rlebsb_pkg::DVD_W;
  localparam int NS = rlebsb_pkg::SPAN_SLOTS;
  localparam int OW = rlebsb_pkg::ORG_W + rlebsb_pkg::PITCH_W;

  rlebsb_pkg::back_state_t state_r, state_nxt;

  // Request and walk state
  rlebsb_pkg::cmd_t                 cmd_r;
  logic [rlebsb_pkg::COL_W-1:0]     column_r, newcol_r;
  logic [DW-1:0]                    rows_left_r;
  logic [OB-1:0]                    row_base_r, prod_r;
  logic [VW-1:0]                    full_r;

  // Planned spans
  logic [NS-1:0]                    slot_v_r;
  rlebsb_pkg::span_t                slot_r [NS];

  // Output stage
  logic                             out_valid_r;
  rlebsb_pkg::span_t                out_span_r;
  logic [rlebsb_pkg::COLOR_W-1:0]   out_color_r;
  logic                             out_last_r;

  // Divider
  logic                             div_start, div_done;
  logic [VW-1:0]                    div_dividend, div_quot;
  logic [DW-1:0]                    div_rem;

  logic [DW-1:0]                    width;
  logic [DW-1:0]                    c_ext;
  logic                             cpos, col_big;
  logic [DW-1:0]                    rows1;
  logic [OB-1:0]                    step_off;
  logic [OW-1:0]                    org_prod;
  logic [OB-1:0]                    org_off;
  logic [rlebsb_pkg::PROD_W-1:0]    mul_full;

  logic                             p_emit;
  logic [NS-1:0]                    plan_v;
  rlebsb_pkg::span_t                plan_span [NS];
  logic [VW-1:0]                    k2;
  logic [DW-1:0]                    rows_after;

  logic                             tail_go;
  logic [NS-1:0]                    tail_v;
  rlebsb_pkg::span_t                tail_span [NS];

  logic                             out_load;
  logic [rlebsb_pkg::SLOT_IDX_W-1:0] sel;
  logic [NS-1:0]                    pick_oh, rest_v;

  rlebsb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (width),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Shared operands; fold the column only for requests that walk or fill
  assign width    = rlebsb_pkg::eff_width(cfg.bitmap_width);
  assign c_ext    = DW'(column_r);
  assign cpos     = (column_r != '0);
  assign col_big  = (c_ext >= width) && (cmd_r.run_valid || cmd_r.fin);
  assign rows1    = rows_left_r - DW'(cpos);
  assign step_off = cpos ? OB'(cfg.line_pitch) : '0;
  assign org_prod = OW'(cfg.origin_y) * OW'(cfg.line_pitch);
  assign org_off  = OB'(org_prod) + OB'(cfg.origin_x);
  assign mul_full = rlebsb_pkg::PROD_W'(full_r) * rlebsb_pkg::PROD_W'(cfg.line_pitch);

  // Plan the run: partial first row, block of whole rows, partial last row
  always_comb begin
    p_emit = cmd_r.run_fg && (rows_left_r != '0) && (cmd_r.run_len != '0);
    k2     = full_r - VW'(cpos);

    plan_v[0]              = p_emit && cpos;
    plan_span[0].offset    = row_base_r + OB'(column_r);
    plan_span[0].length    = (full_r != '0) ? (width - c_ext) : cmd_r.run_len[DW-1:0];
    plan_span[0].rows      = DW'(1);

    plan_v[1]              = p_emit && (full_r > VW'(cpos)) && (rows1 != '0);
    plan_span[1].offset    = row_base_r + step_off;
    plan_span[1].length    = width;
    plan_span[1].rows      = (k2 > VW'(rows1)) ? rows1 : k2[DW-1:0];

    plan_v[2]              = p_emit && (newcol_r != '0) && (!cpos || (full_r != '0)) &&
                             (full_r < VW'(rows_left_r));
    plan_span[2].offset    = row_base_r + prod_r;
    plan_span[2].length    = DW'(newcol_r);
    plan_span[2].rows      = DW'(1);

    rows_after = (full_r >= VW'(rows_left_r)) ? '0 : (rows_left_r - full_r[DW-1:0]);
  end

  // Plan the tail fill: rest of the current row, then every remaining row
  always_comb begin
    tail_go = cmd_r.fin && cmd_r.tail_fg && (rows_left_r != '0);

    tail_v[0]           = cpos;
    tail_span[0].offset = row_base_r + OB'(column_r);
    tail_span[0].length = width - c_ext;
    tail_span[0].rows   = DW'(1);

    tail_v[1]           = (rows1 != '0);
    tail_span[1].offset = row_base_r + step_off;
    tail_span[1].length = width;
    tail_span[1].rows   = rows1;

    tail_v[2]           = 1'b0;
    tail_span[2]        = '0;
  end

  // Pick the first pending span
  always_comb begin
    priority if (slot_v_r[0]) begin
      sel = rlebsb_pkg::SLOT_IDX_W'(0);
    end else if (slot_v_r[1]) begin
      sel = rlebsb_pkg::SLOT_IDX_W'(1);
    end else begin
      sel = rlebsb_pkg::SLOT_IDX_W'(2);
    end
    pick_oh = NS'(1) << sel;
    rest_v  = slot_v_r & ~pick_oh;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlebsb_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = q_cmd.start ? rlebsb_pkg::BK_INIT : rlebsb_pkg::BK_REDUCE;
        end
      end
      rlebsb_pkg::BK_INIT:   state_nxt = rlebsb_pkg::BK_REDUCE;
      rlebsb_pkg::BK_REDUCE: state_nxt = col_big ? rlebsb_pkg::BK_RDIV : rlebsb_pkg::BK_RUN;
      rlebsb_pkg::BK_RDIV: begin
        if (div_done) begin
          state_nxt = rlebsb_pkg::BK_RUN;
        end
      end
      rlebsb_pkg::BK_RUN: begin
        state_nxt = cmd_r.run_valid ? rlebsb_pkg::BK_DIV : rlebsb_pkg::BK_TAIL;
      end
      rlebsb_pkg::BK_DIV: begin
        if (div_done) begin
          state_nxt = rlebsb_pkg::BK_MUL;
        end
      end
      rlebsb_pkg::BK_MUL:  state_nxt = rlebsb_pkg::BK_PLAN;
      rlebsb_pkg::BK_PLAN: state_nxt = rlebsb_pkg::BK_TAIL;
      rlebsb_pkg::BK_TAIL: state_nxt = rlebsb_pkg::BK_EMIT;
      rlebsb_pkg::BK_EMIT: begin
        if (slot_v_r == '0) begin
          state_nxt = rlebsb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rlebsb_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = VW'(column_r);
    out_load     = 1'b0;
    unique case (state_r)
      rlebsb_pkg::BK_IDLE:   q_pop = q_valid;
      rlebsb_pkg::BK_REDUCE: div_start = col_big;
      rlebsb_pkg::BK_RUN: begin
        div_start    = cmd_r.run_valid;
        div_dividend = VW'(column_r) + VW'(cmd_r.run_len);
      end
      rlebsb_pkg::BK_EMIT: begin
        out_load = (slot_v_r != '0) && (!out_valid_r || !out_stall);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlebsb_pkg::BK_IDLE;
      slot_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rlebsb_pkg::BK_PLAN) begin
        slot_v_r <= plan_v;
      end else if ((state_r == rlebsb_pkg::BK_TAIL) && tail_go) begin
        slot_v_r <= tail_v;
      end else if (out_load) begin
        slot_v_r <= rest_v;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk state and span payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      rlebsb_pkg::BK_IDLE: begin
        if (q_pop) begin
          cmd_r <= q_cmd;
        end
      end
      rlebsb_pkg::BK_INIT: begin
        column_r    <= '0;
        rows_left_r <= rlebsb_pkg::eff_height(cfg.bitmap_height);
        row_base_r  <= org_off;
      end
      rlebsb_pkg::BK_RDIV: begin
        if (div_done) begin
          column_r <= div_rem[rlebsb_pkg::COL_W-1:0];
        end
      end
      rlebsb_pkg::BK_DIV: begin
        if (div_done) begin
          full_r   <= div_quot;
          newcol_r <= div_rem[rlebsb_pkg::COL_W-1:0];
        end
      end
      rlebsb_pkg::BK_MUL: begin
        prod_r <= mul_full[OB-1:0];
      end
      rlebsb_pkg::BK_PLAN: begin
        column_r    <= newcol_r;
        rows_left_r <= rows_after;
        row_base_r  <= row_base_r + prod_r;
        for (int i = 0; i < NS; i++) begin
          slot_r[i] <= plan_span[i];
        end
      end
      rlebsb_pkg::BK_TAIL: begin
        if (tail_go) begin
          for (int i = 0; i < NS; i++) begin
            slot_r[i] <= tail_span[i];
          end
        end
      end
      default: begin
        if (out_load) begin
          out_span_r  <= slot_r[sel];
          out_color_r <= cfg.draw_color;
          out_last_r  <= (rest_v == '0);
        end
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_span_offset = out_span_r.offset;
  assign out_span_length = out_span_r.length;
  assign out_span_rows   = out_span_r.rows;
  assign out_pixel_value = out_color_r;
  assign out_last_span   = out_last_r;

endmodule

`default_nettype wire
